// ===== design/ptq_pkg.sv =====
package ptq_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = 4;
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [9:0] USEC_PER_MS = 10'd1000;
	// ceil(2^35 / 125): exact quotient by 125 for any 28-bit dividend
	localparam logic [28:0] MS_RECIP = 29'd274877907;
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// one timer slot as it travels along the chain, period kept as sec and usec
	typedef struct packed {
		logic        run;
		logic [31:0] sec;
		logic [19:0] usec;
		logic [21:0] psec;
		logic [19:0] pusec;
		logic [SLOT_W-1:0] id;
	} slot_t;

	// a before b, strictly
	function automatic logic time_lt(input logic [31:0] as, input logic [19:0] au,
			input logic [31:0] bs, input logic [19:0] bu);
		time_lt = (as != bs) ? (as < bs) : (au < bu);
	endfunction
endpackage

// ===== design/ptq_cell.sv =====
module ptq_cell import ptq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [SLOT_W-1:0] init_id,
	input  slot_t             prev,
	output slot_t             cur
);
	slot_t data_q;
	logic  run_q;
	logic [SLOT_W-1:0] id_q;

	// run bit and slot id are control, the rest is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			id_q <= init_id;
		end else if (shift) begin
			run_q <= prev.run;
			id_q <= prev.id;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= prev;
		end
	end

	always_comb begin
		cur = data_q;
		cur.run = run_q;
		cur.id = id_q;
	end
endmodule

// ===== design/periodic_timer_queue.sv =====
// Periodic timer queue for NUM_SLOTS slots kept in a ring of cells that rotates one
// slot per cycle past a single head unit while a command or a tick scan is running.
// A stop takes one full rotation to find the slot and modify it in passing; the next
// item is taken only once that rotation is over. A start first splits its period
// into seconds and microseconds, then rotates in the same way. An unknown op is
// dropped in the cycle it arrives. A tick first folds the carried seconds into the
// clock (two at most), then runs rounds, each a rotation plus one closing state.
// Each round finds the earliest due unfired slot; the next round reloads it while
// searching again, and its closing state hands the firing to the output once the
// output register is free, flagging last when nothing is left.
module periodic_timer_queue import ptq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  slot_id,
	input  logic [30:0] period_ms,
	input  logic [19:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  fired_slot,
	output logic [31:0] due_sec,
	output logic [19:0] due_usec,
	output logic        last
);
	typedef enum logic [2:0] {S_IDLE, S_DIV, S_REM, S_CMD, S_CARRY, S_SCAN, S_WAIT} state_t;

	state_t state_q;
	logic [1:0]  op_q;
	logic [3:0]  slot_q;
	logic [30:0] period_q;
	logic [21:0] per_sec_q;
	logic [19:0] per_usec_q;
	logic [31:0] clk_sec_q;
	logic [20:0] clk_usec_q;
	logic [IDX_W-1:0] pos_q;
	logic [NUM_SLOTS-1:0] fired_q;
	// best candidate in the current rotation
	logic        bfound_q;
	logic [SLOT_W-1:0] bid_q;
	logic [31:0] bsec_q;
	logic [19:0] busec_q;
	// pending firing chosen in the previous rotation
	logic        pend_q;
	logic [SLOT_W-1:0] pid_q;
	logic [31:0] cap_sec_q;
	logic [19:0] cap_usec_q;

	slot_t cells [NUM_SLOTS];
	slot_t head, head_new;
	logic  shift;

	// ring of cells, head is cell 0, rotates toward it
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_ring
		if (g == NUM_SLOTS - 1) begin : g_tail
			ptq_cell u_cell (.clk, .arst_n, .shift(shift), .init_id(SLOT_W'(g)),
				.prev(head_new), .cur(cells[g]));
		end else begin : g_mid
			ptq_cell u_cell (.clk, .arst_n, .shift(shift), .init_id(SLOT_W'(g)),
				.prev(cells[g + 1]), .cur(cells[g]));
		end
	end
	assign head = cells[0];

	// period split: quotient by reciprocal, remainder in the low 20 bits
	logic [56:0] recip_prod;
	logic [19:0] ms_usec;
	logic [19:0] sec_usec;
	always_comb begin
		recip_prod = 57'(period_q[30:3]) * 57'(MS_RECIP);
		ms_usec = 20'(period_q * 31'(USEC_PER_MS));
		sec_usec = 20'(per_sec_q * 22'(USEC_PER_SEC));
	end

	// deadline plus period on a reload, clock plus period on a start, normalized
	logic [21:0] inc_sec;
	logic [19:0] inc_usec;
	logic [20:0] sum_u;
	logic [31:0] base_sec;
	logic [19:0] base_usec;
	logic [31:0] add_sec;
	logic [19:0] add_usec;
	logic        is_pend;
	always_comb begin
		is_pend = (state_q == S_SCAN) && pend_q && (head.id == pid_q);
		base_sec = is_pend ? head.sec : clk_sec_q;
		base_usec = is_pend ? head.usec : clk_usec_q[19:0];
		inc_sec = is_pend ? head.psec : per_sec_q;
		inc_usec = is_pend ? head.pusec : per_usec_q;
		sum_u = {1'b0, base_usec} + {1'b0, inc_usec};
		add_sec = base_sec + {10'd0, inc_sec};
		add_usec = sum_u[19:0];
		if (sum_u >= {1'b0, USEC_PER_SEC}) begin
			add_usec = 20'(sum_u - {1'b0, USEC_PER_SEC});
			add_sec = add_sec + 32'd1;
		end
	end

	// head update as it passes
	always_comb begin
		head_new = head;
		if (state_q == S_CMD && head.id == slot_q) begin
			if (op_q == OP_START && !head.run) begin
				head_new.run = 1'b1;
				head_new.sec = add_sec;
				head_new.usec = add_usec;
				head_new.psec = per_sec_q;
				head_new.pusec = per_usec_q;
			end else if (op_q == OP_STOP) begin
				head_new.run = 1'b0;
			end
		end else if (is_pend) begin
			head_new.sec = add_sec;
			head_new.usec = add_usec;
		end
	end

	logic due_here, out_free, emit;
	assign out_free = !out_valid || out_ready;
	assign due_here = head.run && !fired_q[head.id]
		&& !time_lt(clk_sec_q, clk_usec_q[19:0], head.sec, head.usec)
		&& !is_pend;
	assign shift = (state_q == S_CMD) || (state_q == S_SCAN);
	assign in_ready = (state_q == S_IDLE);
	assign emit = (state_q == S_WAIT) && pend_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_TICK;
			slot_q <= '0;
			period_q <= '0;
			per_sec_q <= '0;
			per_usec_q <= '0;
			clk_sec_q <= '0;
			clk_usec_q <= '0;
			pos_q <= '0;
			fired_q <= '0;
			bfound_q <= 1'b0;
			bid_q <= '0;
			bsec_q <= '0;
			busec_q <= '0;
			pend_q <= 1'b0;
			pid_q <= '0;
			cap_sec_q <= '0;
			cap_usec_q <= '0;
			out_valid <= 1'b0;
			fired_slot <= '0;
			due_sec <= '0;
			due_usec <= '0;
			last <= 1'b0;
		end else begin
			// output item, handed over at the close of a rotation
			if (emit) begin
				out_valid <= 1'b1;
				fired_slot <= pid_q;
				due_sec <= cap_sec_q;
				due_usec <= cap_usec_q;
				last <= !bfound_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						slot_q <= slot_id;
						period_q <= period_ms;
						pos_q <= '0;
						if (op == OP_TICK) begin
							clk_usec_q <= {1'b0, clk_usec_q[19:0]} + {1'b0, elapsed_us};
							fired_q <= '0;
							bfound_q <= 1'b0;
							pend_q <= 1'b0;
							state_q <= S_CARRY;
						end else if (op == OP_START) begin
							state_q <= S_DIV;
						end else if (op == OP_STOP) begin
							state_q <= S_CMD;
						end
					end
				end
				S_DIV: begin
					per_sec_q <= recip_prod[56:35];
					state_q <= S_REM;
				end
				S_REM: begin
					per_usec_q <= ms_usec - sec_usec;
					state_q <= S_CMD;
				end
				S_CMD: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == IDX_W'(NUM_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_CARRY: begin
					if (clk_usec_q >= 21'(USEC_PER_SEC)) begin
						clk_usec_q <= clk_usec_q - 21'(USEC_PER_SEC);
						clk_sec_q <= clk_sec_q + 32'd1;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// capture the pending firing as it is reloaded
					if (is_pend) begin
						cap_sec_q <= head.sec;
						cap_usec_q <= head.usec;
						fired_q[head.id] <= 1'b1;
					end
					if (due_here && (!bfound_q ||
							time_lt(head.sec, head.usec, bsec_q, busec_q))) begin
						bfound_q <= 1'b1;
						bid_q <= head.id;
						bsec_q <= head.sec;
						busec_q <= head.usec;
					end
					pos_q <= pos_q + 1'b1;
					if (pos_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// end of rotation, held while a pending firing waits for the output: next round or done
					if (!pend_q || out_free) begin
						pos_q <= '0;
						if (bfound_q) begin
							pend_q <= 1'b1;
							pid_q <= bid_q;
							bfound_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							pend_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/ptq_checker.sv =====
module ptq_checker import ptq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] fired_slot,
	input logic [19:0] due_usec,
	input logic       last
);
	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fired_slot) && $stable(last))
		else $error("output item changed while stalled");
	// deadlines are normalized
	a_usec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> due_usec < USEC_PER_SEC)
		else $error("due_usec out of range");
	// no new item while results are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken mid tick");
endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (.clk, .arst_n, .in_ready,
	.out_valid, .out_ready, .fired_slot, .due_usec, .last);
